@@ src/swd_host_transaction_engine_assert.svh @@
// Assertion macros for the SWD host transaction engine.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SWD_HOST_TRANSACTION_ENGINE_ASSERT_SVH
`define SWD_HOST_TRANSACTION_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// check outside reset
`define SWD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("SWD engine check failed");
// check that also holds while reset is asserted
`define SWD_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("SWD engine reset check failed");
`else
`define SWD_ASSERT(lbl, clk, rst_n, prop)
`define SWD_ASSERT_RST(lbl, clk, prop)
`endif

`endif

@@ src/swd_pkg.sv @@
// Shared types and codes for the SWD host transaction engine.
// No dependencies; imported by every module of the block.
package swd_pkg;

    localparam int DATA_BITS = 32;

    // command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_LRST  = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_RETRY_LIMIT  = 2'd0;
    localparam logic [1:0] REG_IDLE_CLOCKS  = 2'd1;
    localparam logic [1:0] REG_RESET_CLOCKS = 2'd2;

    // ack / status codes
    localparam logic [2:0] ACK_OK      = 3'd1;
    localparam logic [2:0] ACK_WAIT    = 3'd2;
    localparam logic [2:0] ACK_OK_ALT  = 3'd3;
    localparam logic [2:0] ACK_FAULT   = 3'd4;
    localparam logic [2:0] ACK_NO_RESP = 3'd7;

    localparam logic [3:0] RETRY_LIMIT_RST  = 4'd10;
    localparam logic [5:0] IDLE_CLOCKS_RST  = 6'd20;
    localparam logic [7:0] RESET_CLOCKS_RST = 8'd60;
    localparam logic [7:0] HEADER_BITS      = 8'd8;
    localparam logic [7:0] ACK_BITS         = 8'd3;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_LRST   = 4'd1,
        PH_PRE    = 4'd2,
        PH_HDR    = 4'd3,
        PH_TRN1   = 4'd4,
        PH_ACK    = 4'd5,
        PH_TRN2   = 4'd6,
        PH_WDATA  = 4'd7,
        PH_WPAR   = 4'd8,
        PH_WEXTRA = 4'd9,
        PH_RDATA  = 4'd10,
        PH_RPAR   = 4'd11,
        PH_ENDTRN = 4'd12
    } phase_t;

    typedef struct packed {
        logic [3:0] retry_limit;
        logic [5:0] idle_clocks;
        logic [7:0] reset_clocks;
    } cfg_t;

    typedef struct packed {
        logic                 clock_pulse;
        logic                 swdio_out;
        logic                 swdio_oe;
        logic                 busy;
        logic                 done;
        logic [2:0]           ack_status;
        logic                 parity_error;
        logic [DATA_BITS-1:0] read_data;
    } res_t;

endpackage

@@ src/swd_cfg.sv @@
// Configuration register file of the SWD engine: retry limit, idle and reset clocks.
// Depends on swd_pkg.
module swd_cfg
    import swd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RETRY_LIMIT:  cfg_next.retry_limit  = cfg_data[3:0];
                REG_IDLE_CLOCKS:  cfg_next.idle_clocks  = cfg_data[5:0];
                REG_RESET_CLOCKS: cfg_next.reset_clocks = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.retry_limit  <= RETRY_LIMIT_RST;
            cfg_reg.idle_clocks  <= IDLE_CLOCKS_RST;
            cfg_reg.reset_clocks <= RESET_CLOCKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ src/swd_core.sv @@
// SWD transaction sequencer: phase state machine, bit counter, shift and hold registers.
// Depends on swd_pkg and swd_host_transaction_engine_assert.svh.
`include "swd_host_transaction_engine_assert.svh"

module swd_core
    import swd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  cfg_t                 cfg,
    input  logic [1:0]           command,
    input  logic [7:0]           header,
    input  logic [DATA_BITS-1:0] write_data,
    input  logic                 swdio_in,
    output res_t                 res
);

    phase_t               phase_reg, phase_next;
    logic [7:0]           bit_counter_reg, bit_counter_next;
    logic [DATA_BITS-1:0] shift_word_reg, shift_word_next;
    logic [7:0]           header_hold_reg, header_hold_next;
    logic [DATA_BITS-1:0] write_hold_reg, write_hold_next;
    logic [3:0]           attempts_left_reg, attempts_left_next;
    logic [2:0]           ack_hold_reg, ack_hold_next;
    logic                 parity_hold_reg, parity_hold_next;
    logic                 is_read_reg, is_read_next;

    logic       start_attempt;
    logic       finish;
    logic [2:0] status;
    logic [7:0] bc_dec;
    logic [2:0] hdr_idx;
    logic [1:0] ack_idx;

    // status of a finished attempt
    function automatic logic [2:0] attempt_status(logic [2:0] a, logic rd);
        logic [2:0] s;
        s = ACK_NO_RESP;
        if (a == ACK_OK || a == ACK_WAIT || a == ACK_FAULT)
            s = a;
        else if (rd && a == ACK_OK_ALT)
            s = a;
        return s;
    endfunction

    assign bc_dec  = bit_counter_reg - 8'd1;
    assign hdr_idx = 3'd0 - bit_counter_reg[2:0];
    assign ack_idx = 2'd3 - bit_counter_reg[1:0];
    assign status  = attempt_status(ack_hold_reg, is_read_reg);

    // next state and result for one item
    always_comb
    begin
        phase_next         = phase_reg;
        bit_counter_next   = bit_counter_reg;
        shift_word_next    = shift_word_reg;
        header_hold_next   = header_hold_reg;
        write_hold_next    = write_hold_reg;
        attempts_left_next = attempts_left_reg;
        ack_hold_next      = ack_hold_reg;
        parity_hold_next   = parity_hold_reg;
        is_read_next       = is_read_reg;
        res                = '0;
        start_attempt      = 1'b0;
        finish             = 1'b0;

        if (command != CMD_TICK)
        begin
            if (phase_reg != PH_IDLE)
            begin
                res.busy = 1'b1;
            end
            else if (command == CMD_LRST)
            begin
                is_read_next  = 1'b0;
                ack_hold_next = '0;
                if (cfg.reset_clocks == 8'd0)
                begin
                    res.done = 1'b1;
                end
                else
                begin
                    phase_next       = PH_LRST;
                    bit_counter_next = cfg.reset_clocks;
                    res.busy         = 1'b1;
                end
            end
            else
            begin
                is_read_next       = (command == CMD_READ);
                header_hold_next   = header;
                write_hold_next    = write_data;
                attempts_left_next = (cfg.retry_limit != 4'd0) ? cfg.retry_limit : 4'd1;
                start_attempt      = 1'b1;
                res.busy           = 1'b1;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            res.clock_pulse = 1'b1;
            res.busy        = 1'b1;
            unique case (phase_reg)
                PH_LRST:
                begin
                    res.swdio_out    = 1'b1;
                    res.swdio_oe     = 1'b1;
                    bit_counter_next = bc_dec;
                    if (bc_dec == 8'd0)
                    begin
                        phase_next = PH_IDLE;
                        res.busy   = 1'b0;
                        res.done   = 1'b1;
                    end
                end
                PH_PRE:
                begin
                    res.swdio_oe     = 1'b1;
                    bit_counter_next = bc_dec;
                    if (bc_dec == 8'd0)
                    begin
                        phase_next       = PH_HDR;
                        bit_counter_next = HEADER_BITS;
                    end
                end
                PH_HDR:
                begin
                    res.swdio_out    = header_hold_reg[hdr_idx];
                    res.swdio_oe     = 1'b1;
                    bit_counter_next = bc_dec;
                    if (bc_dec == 8'd0)
                        phase_next = PH_TRN1;
                end
                PH_TRN1:
                begin
                    phase_next       = PH_ACK;
                    bit_counter_next = ACK_BITS;
                end
                PH_ACK:
                begin
                    ack_hold_next    = ack_hold_reg | (3'(swdio_in) << ack_idx);
                    bit_counter_next = bc_dec;
                    if (bc_dec == 8'd0)
                    begin
                        if (!is_read_reg)
                        begin
                            phase_next = PH_TRN2;
                        end
                        else if (ack_hold_next == ACK_OK || ack_hold_next == ACK_OK_ALT)
                        begin
                            phase_next       = PH_RDATA;
                            bit_counter_next = 8'(DATA_BITS);
                            shift_word_next  = '0;
                        end
                        else
                        begin
                            phase_next = PH_ENDTRN;
                        end
                    end
                end
                PH_TRN2:
                begin
                    if (ack_hold_reg == ACK_OK)
                    begin
                        phase_next       = PH_WDATA;
                        bit_counter_next = 8'(DATA_BITS);
                        shift_word_next  = write_hold_reg;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                PH_WDATA:
                begin
                    res.swdio_out    = shift_word_reg[0];
                    res.swdio_oe     = 1'b1;
                    shift_word_next  = shift_word_reg >> 1;
                    bit_counter_next = bc_dec;
                    if (bc_dec == 8'd0)
                        phase_next = PH_WPAR;
                end
                PH_WPAR:
                begin
                    res.swdio_out = parity_hold_reg;
                    res.swdio_oe  = 1'b1;
                    phase_next    = PH_WEXTRA;
                end
                PH_WEXTRA:
                begin
                    res.swdio_oe = 1'b1;
                    finish       = 1'b1;
                end
                PH_RDATA:
                begin
                    shift_word_next  = {swdio_in, shift_word_reg[DATA_BITS-1:1]};
                    bit_counter_next = bc_dec;
                    if (bc_dec == 8'd0)
                        phase_next = PH_RPAR;
                end
                PH_RPAR:
                begin
                    parity_hold_next = (^shift_word_reg) ^ swdio_in;
                    phase_next       = PH_ENDTRN;
                end
                PH_ENDTRN:
                begin
                    finish = 1'b1;
                end
                default:
                begin
                    phase_next      = PH_IDLE;
                    res.clock_pulse = 1'b0;
                    res.busy        = 1'b0;
                end
            endcase
        end

        // end of attempt: retry on no response, else complete
        if (finish)
        begin
            if (status == ACK_NO_RESP && attempts_left_reg > 4'd1)
            begin
                attempts_left_next = attempts_left_reg - 4'd1;
                start_attempt      = 1'b1;
                res.busy           = 1'b1;
            end
            else
            begin
                res.done       = 1'b1;
                res.ack_status = status;
                if (is_read_reg && (status == ACK_OK || status == ACK_OK_ALT))
                begin
                    res.parity_error = parity_hold_reg;
                    res.read_data    = shift_word_reg;
                end
                phase_next = PH_IDLE;
                res.busy   = 1'b0;
            end
        end

        // set up idle clocks or header for a new attempt
        if (start_attempt)
        begin
            ack_hold_next    = '0;
            shift_word_next  = '0;
            parity_hold_next = is_read_next ? 1'b0 : (^write_hold_next);
            if (cfg.idle_clocks != 6'd0)
            begin
                phase_next       = PH_PRE;
                bit_counter_next = {2'b00, cfg.idle_clocks};
            end
            else
            begin
                phase_next       = PH_HDR;
                bit_counter_next = HEADER_BITS;
            end
        end
    end

    // state registers, advanced once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            bit_counter_reg   <= '0;
            shift_word_reg    <= '0;
            header_hold_reg   <= '0;
            write_hold_reg    <= '0;
            attempts_left_reg <= '0;
            ack_hold_reg      <= '0;
            parity_hold_reg   <= 1'b0;
            is_read_reg       <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg         <= phase_next;
            bit_counter_reg   <= bit_counter_next;
            shift_word_reg    <= shift_word_next;
            header_hold_reg   <= header_hold_next;
            write_hold_reg    <= write_hold_next;
            attempts_left_reg <= attempts_left_next;
            ack_hold_reg      <= ack_hold_next;
            parity_hold_reg   <= parity_hold_next;
            is_read_reg       <= is_read_next;
        end
    end

    `SWD_ASSERT(a_done_not_busy, clk, rst_n, fire && res.done |-> !res.busy)
    `SWD_ASSERT(a_idle_tick_stays, clk, rst_n,
        fire && phase_reg == PH_IDLE && command == CMD_TICK |=> phase_reg == PH_IDLE)
    `SWD_ASSERT(a_attempts_live, clk, rst_n,
        phase_reg != PH_IDLE && phase_reg != PH_LRST |-> attempts_left_reg != 4'd0)
    `SWD_ASSERT(a_status_only_done, clk, rst_n,
        !res.done |-> res.ack_status == 3'd0 && res.read_data == '0)

endmodule

@@ src/swd_out_reg.sv @@
// Result register of the SWD engine: holds one result beat until the consumer takes it.
// Depends on swd_pkg and swd_host_transaction_engine_assert.svh.
`include "swd_host_transaction_engine_assert.svh"

module swd_out_reg
    import swd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  res_t res,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    output res_t res_out
);

    logic out_valid_reg, out_valid_next;
    res_t res_reg;

    // the input waits only while a held beat is stalled
    assign in_stall       = out_valid_reg && out_stall;
    assign out_valid_next = fire || (out_valid_reg && out_stall);
    assign out_valid      = out_valid_reg;
    assign res_out        = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res;
    end

    `SWD_ASSERT(a_fire_loads, clk, rst_n, fire |=> out_valid_reg && res_reg == $past(res))
    `SWD_ASSERT(a_no_fire_when_held, clk, rst_n, out_valid_reg && out_stall |-> !fire)
    `SWD_ASSERT_RST(a_reset_empty, clk, !rst_n |-> !out_valid_reg)

endmodule

@@ src/swd_host_transaction_engine.sv @@
// Top level of the SWD host transaction engine: config registers, sequencer, result register.
// Depends on swd_pkg, swd_cfg, swd_core and swd_out_reg.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------------
//  in      | in_valid / in_stall  | command, header, write_data, swdio_in
//  out     | out_valid / out_stall| clock_pulse, swdio_out, swdio_oe, busy_res,
//          |                      | done_res, ack_status, parity_error, read_data
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item is accepted per cycle; the result register shows its result the next cycle.
// The single result register sets the rate: in_stall is high only while a result is held
// and out_stall is high, so an item can be accepted in the same cycle a result is taken.
// Reset clears the phase to idle and loads retry_limit 10, idle_clocks 20, reset_clocks 60;
// there is no clearing pass. cfg_ready is always high.
module swd_host_transaction_engine
    import swd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           command,
    input  logic [7:0]           header,
    input  logic [DATA_BITS-1:0] write_data,
    input  logic                 swdio_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 clock_pulse,
    output logic                 swdio_out,
    output logic                 swdio_oe,
    output logic                 busy_res,
    output logic                 done_res,
    output logic [2:0]           ack_status,
    output logic                 parity_error,
    output logic [DATA_BITS-1:0] read_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data
);

    cfg_t cfg;
    res_t res;
    res_t res_out;
    logic fire;

    assign fire = in_valid && !in_stall;

    swd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    swd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .cfg        (cfg),
        .command    (command),
        .header     (header),
        .write_data (write_data),
        .swdio_in   (swdio_in),
        .res        (res)
    );

    swd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .res       (res),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_out   (res_out)
    );

    assign clock_pulse  = res_out.clock_pulse;
    assign swdio_out    = res_out.swdio_out;
    assign swdio_oe     = res_out.swdio_oe;
    assign busy_res     = res_out.busy;
    assign done_res     = res_out.done;
    assign ack_status   = res_out.ack_status;
    assign parity_error = res_out.parity_error;
    assign read_data    = res_out.read_data;

endmodule
